### rtl/dmdf_pkg.sv
// ============================================================================
// dmdf_pkg
// Shared types and constants for the direct-mapped duplicate filter: the
// item structs on both channels, the configuration set and the job word
// that travels from the front part to the back part.
// ============================================================================
`default_nettype none

package dmdf_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Register indexes
    typedef logic [CFG_INDEX_W-1:0] reg_index_t;
    localparam reg_index_t REG_TEAM_NUMBER          = 2'd0;
    localparam reg_index_t REG_SERVICE_NUMBER       = 2'd1;
    localparam reg_index_t REG_ROUND_BUCKET_COUNT   = 2'd2;
    localparam reg_index_t REG_PAYLOAD_BUCKET_COUNT = 2'd3;

    // Reset values of the bucket counts
    localparam logic [6:0] ROUND_BUCKETS_RESET   = 7'd26;
    localparam logic [4:0] PAYLOAD_BUCKETS_RESET = 5'd5;

    // Remainder unit: dividend bits retired per cycle, steps per item
    localparam int REM_BITS_PER_STEP = 4;
    localparam int REM_STEPS         = 16 / REM_BITS_PER_STEP;

    // Input item
    typedef struct packed {
        logic [15:0] submitter_id;
        logic [15:0] owner_id;
        logic [15:0] service_index;
        logic [15:0] round_number;
        logic [15:0] payload_value;
    } submission_t;

    // Result item
    typedef struct packed {
        logic        possibly_new;
        logic        in_range;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } verdict_t;

    // Configuration set
    typedef struct packed {
        logic [7:0] team_number;
        logic [3:0] service_number;
        logic [6:0] round_bucket_count;
        logic [4:0] payload_bucket_count;
    } cfg_t;

    // Work handed to the back part (slot address travels beside it)
    typedef struct packed {
        logic        check;
        logic [31:0] key;
    } job_t;

endpackage

`default_nettype wire

### rtl/direct_mapped_duplicate_filter_core.sv
// ============================================================================
// direct_mapped_duplicate_filter_core
// Duplicate filter over a direct-mapped store of SLOT_ENTRIES 32-bit words.
// ============================================================================
// After reset the store is cleared one word per cycle; full stays high
// until it is done, while configuration writes are taken at any time.
// Each item then passes through the front part in order: the accept step,
// four steps in which the remainder unit retires four bits of round and
// payload per cycle while the index is packed with one multiply per cycle,
// the final sum and the queueing of the job, which waits while the queue
// is full; a new item is taken only once the last job is queued. The back
// part reads the slot and then compares and writes back for a checked item
// (an unchecked item is handled in its idle state alone), and takes a job
// only while the result register is empty. A two-entry queue between the
// parts and the result register let either side stall without stopping
// the other until the queue is full.
// ============================================================================
`default_nettype none

module direct_mapped_duplicate_filter_core #(
    parameter int SLOT_ENTRIES = 65536
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire dmdf_pkg::submission_t             submission,
    output logic                                   empty,
    input  wire logic                              pop,
    output dmdf_pkg::verdict_t                     verdict,
    input  wire logic                              cfg_we,
    input  wire logic [dmdf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dmdf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import dmdf_pkg::*;

    localparam int QW = $clog2(SLOT_ENTRIES) + $bits(job_t);

    cfg_t            cfg_reg;
    logic            front_idle;
    logic            clearing;
    logic            take;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    logic [QW-1:0]   q_wdata;
    logic [QW-1:0]   q_rdata;

    // Input handshake
    assign full = ~front_idle | clearing;
    assign take = push & ~full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.team_number          <= '0;
            cfg_reg.service_number       <= '0;
            cfg_reg.round_bucket_count   <= ROUND_BUCKETS_RESET;
            cfg_reg.payload_bucket_count <= PAYLOAD_BUCKETS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEAM_NUMBER:          cfg_reg.team_number <= cfg_wdata;
                REG_SERVICE_NUMBER:       cfg_reg.service_number <= cfg_wdata[3:0];
                REG_ROUND_BUCKET_COUNT:   cfg_reg.round_bucket_count <= cfg_wdata[6:0];
                REG_PAYLOAD_BUCKET_COUNT: cfg_reg.payload_bucket_count <= cfg_wdata[4:0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    dmdf_front #(
        .SLOT_ENTRIES (SLOT_ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .submission (submission),
        .cfg        (cfg_reg),
        .idle       (front_idle),
        .q_push     (q_push),
        .q_data     (q_wdata),
        .q_full     (q_full)
    );

    dmdf_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    dmdf_back #(
        .SLOT_ENTRIES (SLOT_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_rdata),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .clearing (clearing),
        .empty    (empty),
        .pop      (pop),
        .verdict  (verdict)
    );

endmodule

`default_nettype wire

### rtl/dmdf_ram.sv
// ============================================================================
// dmdf_ram
// Generic single-port RAM with registered read data.
// ============================================================================
`default_nettype none

module dmdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

`default_nettype wire

### rtl/dmdf_queue.sv
// ============================================================================
// dmdf_queue
// Two-entry queue between the front and back parts.
// ============================================================================
`default_nettype none

module dmdf_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/dmdf_rem.sv
// ============================================================================
// dmdf_rem
// Two-lane restoring remainder unit: round mod round_bucket_count and
// payload mod payload_bucket_count, four dividend bits per cycle.
// ============================================================================
`default_nettype none

module dmdf_rem (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] round_number,
    input  wire logic [15:0] payload_value,
    input  wire logic [6:0]  round_divisor,
    input  wire logic [4:0]  payload_divisor,
    output logic      [6:0]  round_rem,
    output logic      [4:0]  payload_rem
);
    import dmdf_pkg::*;

    logic [15:0] rnd_sh_reg;
    logic [15:0] rnd_sh_next;
    logic [15:0] pay_sh_reg;
    logic [15:0] pay_sh_next;
    logic [6:0]  rrem_reg;
    logic [6:0]  rrem_next;
    logic [4:0]  prem_reg;
    logic [4:0]  prem_next;
    logic [1:0]  step_reg;
    logic        busy_reg;

    assign round_rem   = rrem_reg;
    assign payload_rem = prem_reg;

    // Four shift-compare-subtract steps per lane
    always_comb
    begin
        logic [7:0] rt;
        logic [5:0] pt;
        rrem_next   = rrem_reg;
        prem_next   = prem_reg;
        rnd_sh_next = rnd_sh_reg;
        pay_sh_next = pay_sh_reg;
        rt          = '0;
        pt          = '0;
        for (int i = 0; i < REM_BITS_PER_STEP; i++)
        begin
            rt          = {rrem_next, rnd_sh_next[15]};
            pt          = {prem_next, pay_sh_next[15]};
            rnd_sh_next = {rnd_sh_next[14:0], 1'b0};
            pay_sh_next = {pay_sh_next[14:0], 1'b0};
            if (rt >= round_divisor)
            begin
                rt = rt - round_divisor;
            end
            if (pt >= payload_divisor)
            begin
                pt = pt - payload_divisor;
            end
            rrem_next = rt[6:0];
            prem_next = pt[4:0];
        end
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= 2'd0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'(REM_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rnd_sh_reg <= round_number;
            pay_sh_reg <= payload_value;
            rrem_reg   <= '0;
            prem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rnd_sh_reg <= rnd_sh_next;
            pay_sh_reg <= pay_sh_next;
            rrem_reg   <= rrem_next;
            prem_reg   <= prem_next;
        end
    end

endmodule

`default_nettype wire

### rtl/dmdf_front.sv
// ============================================================================
// dmdf_front
// Front part: takes an item, checks the ids, forms the slot index by
// mixed-radix packing (one multiply per cycle) and queues the job.
// ============================================================================
`default_nettype none

module dmdf_front #(
    parameter int SLOT_ENTRIES = 65536
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   take,
    input  wire dmdf_pkg::submission_t                  submission,
    input  wire dmdf_pkg::cfg_t                         cfg,
    output logic                                        idle,
    output logic                                        q_push,
    output logic [$clog2(SLOT_ENTRIES)+$bits(dmdf_pkg::job_t)-1:0] q_data,
    input  wire logic                                   q_full
);
    import dmdf_pkg::*;

    localparam int AW = $clog2(SLOT_ENTRIES);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_CALC = 4'b0010,
        F_SUM  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t state_reg;
    front_state_t state_next;
    logic [1:0]   step_reg;
    logic [7:0]   sub_reg;
    logic [7:0]   own_reg;
    logic [3:0]   svc_reg;
    logic         ok_reg;
    logic [31:0]  key_reg;
    logic [31:0]  acc_reg;
    logic [31:0]  acc_next;
    logic [31:0]  idx_reg;
    logic [15:0]  sub_id;
    logic [15:0]  own_id;
    logic [15:0]  svc_id;
    logic         ids_ok;
    logic [6:0]   round_rem;
    logic [4:0]   payload_rem;
    job_t         job;

    // Zero-based ids and range check
    assign sub_id = submission.submitter_id - 16'd1;
    assign own_id = submission.owner_id - 16'd1;
    assign svc_id = submission.service_index - 16'd1;
    assign ids_ok = (sub_id < 16'(cfg.team_number))
                  && (own_id < 16'(cfg.team_number))
                  && (svc_id < 16'(cfg.service_number))
                  && (cfg.round_bucket_count != '0)
                  && (cfg.payload_bucket_count != '0);

    dmdf_rem u_rem (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (take),
        .round_number    (submission.round_number),
        .payload_value   (submission.payload_value),
        .round_divisor   (cfg.round_bucket_count),
        .payload_divisor (cfg.payload_bucket_count),
        .round_rem       (round_rem),
        .payload_rem     (payload_rem)
    );

    // One packing multiply per step
    always_comb
    begin
        unique case (step_reg)
            2'd0: acc_next = 32'(sub_reg) * 32'(cfg.service_number) + 32'(svc_reg);
            2'd1: acc_next = 32'(acc_reg[11:0]) * 32'(cfg.team_number) + 32'(own_reg);
            2'd2: acc_next = 32'(acc_reg[19:0]) * 32'(cfg.round_bucket_count);
            2'd3: acc_next = 32'(acc_reg[26:0]) * 32'(cfg.payload_bucket_count);
            default: acc_next = acc_reg;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (take) state_next = F_CALC;
            F_CALC: if (step_reg == 2'(REM_STEPS - 1)) state_next = F_SUM;
            F_SUM:  state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_CALC)
            begin
                step_reg <= step_reg + 2'd1;
            end
            else
            begin
                step_reg <= 2'd0;
            end
        end
    end

    // Item fields and index datapath
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sub_reg <= sub_id[7:0];
            own_reg <= own_id[7:0];
            svc_reg <= svc_id[3:0];
            ok_reg  <= ids_ok;
            key_reg <= {submission.payload_value, submission.round_number};
        end
        if (state_reg == F_CALC)
        begin
            acc_reg <= acc_next;
        end
        if (state_reg == F_SUM)
        begin
            idx_reg <= acc_reg + 32'(round_rem) * 32'(cfg.payload_bucket_count)
                     + 32'(payload_rem);
        end
    end

    // Job to the back part
    assign job.check = ok_reg && (idx_reg < 32'(SLOT_ENTRIES));
    assign job.key   = key_reg;
    assign q_data    = {idx_reg[AW-1:0], job};
    assign q_push    = (state_reg == F_PUSH);
    assign idle      = (state_reg == F_IDLE);

endmodule

`default_nettype wire

### rtl/dmdf_back.sv
// ============================================================================
// dmdf_back
// Back part: clears the slot store after reset, then for each checked
// job swaps the key into its slot, compares with the old word and keeps
// the hit and miss counters, and holds every result for the output side.
// ============================================================================
`default_nettype none

module dmdf_back #(
    parameter int SLOT_ENTRIES = 65536
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic [$clog2(SLOT_ENTRIES)+$bits(dmdf_pkg::job_t)-1:0] q_data,
    input  wire logic                                   q_empty,
    output logic                                        q_pop,
    output logic                                        clearing,
    output logic                                        empty,
    input  wire logic                                   pop,
    output dmdf_pkg::verdict_t                          verdict
);
    import dmdf_pkg::*;

    localparam int AW = $clog2(SLOT_ENTRIES);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_READ  = 3'b100
    } back_state_t;

    back_state_t     state_reg;
    back_state_t     state_next;
    logic [AW-1:0]   clr_cnt_reg;
    logic [AW-1:0]   addr_reg;
    logic [31:0]     key_reg;
    logic [31:0]     hit_reg;
    logic [31:0]     miss_reg;
    logic            res_valid_reg;
    verdict_t        verdict_reg;
    logic [AW-1:0]   q_addr;
    job_t            q_job;
    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [31:0]     ram_wdata;
    logic [31:0]     ram_rdata;
    logic            fresh;
    logic            start;

    assign q_addr   = q_data[AW+$bits(job_t)-1:$bits(job_t)];
    assign q_job    = q_data[$bits(job_t)-1:0];
    assign start    = (state_reg == B_IDLE) && !q_empty && !res_valid_reg;
    assign q_pop    = start;
    assign fresh    = (ram_rdata != key_reg);
    assign clearing = (state_reg == B_CLEAR);
    assign empty    = ~res_valid_reg;
    assign verdict  = verdict_reg;

    // RAM port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = q_addr;
        ram_wdata = key_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            B_IDLE:  ram_addr = q_addr;
            B_READ:
            begin
                ram_we   = 1'b1;
                ram_addr = addr_reg;
            end
            default: ram_we = 1'b0;
        endcase
    end

    dmdf_ram #(
        .WIDTH (32),
        .DEPTH (SLOT_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR: if (clr_cnt_reg == AW'(SLOT_ENTRIES - 1)) state_next = B_IDLE;
            B_IDLE:  if (start && q_job.check) state_next = B_READ;
            B_READ:  state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Control, counters and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            hit_reg       <= '0;
            miss_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (state_reg == B_READ)
            begin
                if (fresh)
                begin
                    miss_reg <= miss_reg + 32'd1;
                end
                else
                begin
                    hit_reg <= hit_reg + 32'd1;
                end
            end
            if ((start && !q_job.check) || (state_reg == B_READ))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Job capture and result payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            addr_reg <= q_addr;
            key_reg  <= q_job.key;
        end
        if (start && !q_job.check)
        begin
            verdict_reg.possibly_new <= 1'b1;
            verdict_reg.in_range     <= 1'b0;
            verdict_reg.hit_total    <= hit_reg;
            verdict_reg.miss_total   <= miss_reg;
        end
        else if (state_reg == B_READ)
        begin
            verdict_reg.possibly_new <= fresh;
            verdict_reg.in_range     <= 1'b1;
            verdict_reg.hit_total    <= fresh ? hit_reg : hit_reg + 32'd1;
            verdict_reg.miss_total   <= fresh ? miss_reg + 32'd1 : miss_reg;
        end
    end

endmodule

`default_nettype wire
